### rtl/two_way_time_sync_fsm_defines.svh
// ----------------------------------------------------------------------------
// Two-way time sync assertion macros
// Shared assertion wrappers for the time synchronization engine checks.
// ----------------------------------------------------------------------------
`ifndef TWO_WAY_TIME_SYNC_FSM_DEFINES_SVH
`define TWO_WAY_TIME_SYNC_FSM_DEFINES_SVH

// Checked at every clock edge while reset is released.
`define TSYNC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define TSYNC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/tsync_pkg.sv
// ----------------------------------------------------------------------------
// Time sync package
// Shared types and constants of the two-way time synchronization engine.
// ----------------------------------------------------------------------------
package tsync_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int ADDR_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_RECV   = 2'd1,
        OP_RESYNC = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_SYNC   = 2'd0,
        PH_ACK    = 2'd1,
        PH_SET    = 2'd2,
        PH_RESYNC = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_WAIT_ACK = 2'd1,
        ST_WAIT_SET = 2'd2,
        ST_SYNCED   = 2'd3
    } state_t;

    typedef struct packed {
        logic   send_valid;
        phase_t send_phase;
        logic   busy;
    } res_ctrl_t;

endpackage

### rtl/tsync_in_reg.sv
// ----------------------------------------------------------------------------
// Time sync input register
// Captures one input item per transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module tsync_in_reg #(
    parameter int TIME_WIDTH = tsync_pkg::TIME_WIDTH_DEF,
    parameter int ADDR_WIDTH = tsync_pkg::ADDR_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            operation,
    input  logic [TIME_WIDTH-1:0] local_time,
    input  logic [ADDR_WIDTH-1:0] peer_addr,
    input  logic                  msg_is_timesync,
    input  logic [1:0]            msg_phase,
    input  logic [TIME_WIDTH-1:0] msg_timestamp,
    input  logic                  take,
    output logic                  hold_valid,
    output logic [1:0]            hold_operation,
    output logic [TIME_WIDTH-1:0] hold_local_time,
    output logic [ADDR_WIDTH-1:0] hold_peer_addr,
    output logic                  hold_msg_is_timesync,
    output logic [1:0]            hold_msg_phase,
    output logic [TIME_WIDTH-1:0] hold_msg_timestamp
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  accept;
    logic [1:0]            operation_reg;
    logic [TIME_WIDTH-1:0] local_time_reg;
    logic [ADDR_WIDTH-1:0] peer_addr_reg;
    logic                  msg_is_timesync_reg;
    logic [1:0]            msg_phase_reg;
    logic [TIME_WIDTH-1:0] msg_timestamp_reg;

    // The stage frees up in the same cycle that the core takes its item.
    assign item_stall = valid_reg && !take;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            operation_reg       <= operation;
            local_time_reg      <= local_time;
            peer_addr_reg       <= peer_addr;
            msg_is_timesync_reg <= msg_is_timesync;
            msg_phase_reg       <= msg_phase;
            msg_timestamp_reg   <= msg_timestamp;
        end
    end

    assign hold_valid           = valid_reg;
    assign hold_operation       = operation_reg;
    assign hold_local_time      = local_time_reg;
    assign hold_peer_addr       = peer_addr_reg;
    assign hold_msg_is_timesync = msg_is_timesync_reg;
    assign hold_msg_phase       = msg_phase_reg;
    assign hold_msg_timestamp   = msg_timestamp_reg;

endmodule

### rtl/tsync_core.sv
// ----------------------------------------------------------------------------
// Time sync protocol core
// Holds the protocol state, latency and clock offset, and works out the
// result of the held item in one pass.
// ----------------------------------------------------------------------------
module tsync_core #(
    parameter int TIME_WIDTH = tsync_pkg::TIME_WIDTH_DEF,
    parameter int ADDR_WIDTH = tsync_pkg::ADDR_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [1:0]             operation,
    input  logic [TIME_WIDTH-1:0]  local_time,
    input  logic [ADDR_WIDTH-1:0]  peer_addr,
    input  logic                   msg_is_timesync,
    input  logic [1:0]             msg_phase,
    input  logic [TIME_WIDTH-1:0]  msg_timestamp,
    output tsync_pkg::res_ctrl_t   res_ctrl,
    output logic [ADDR_WIDTH-1:0]  res_addr,
    output logic [TIME_WIDTH-1:0]  res_timestamp,
    output logic [TIME_WIDTH-1:0]  res_synced_time
);

    tsync_pkg::state_t     state_reg;
    tsync_pkg::state_t     state_next;
    logic [TIME_WIDTH-1:0] latency_reg;
    logic [TIME_WIDTH-1:0] latency_next;
    logic [TIME_WIDTH-1:0] offset_reg;
    logic [TIME_WIDTH-1:0] offset_next;
    logic [TIME_WIDTH-1:0] round_trip;
    logic [TIME_WIDTH-1:0] half_trip;
    logic                  send;
    tsync_pkg::phase_t     send_phase;

    assign round_trip = local_time - latency_reg;
    assign half_trip  = round_trip >> 1;

    always_comb
    begin
        state_next   = state_reg;
        latency_next = latency_reg;
        offset_next  = offset_reg;
        send         = 1'b0;
        send_phase   = tsync_pkg::PH_SYNC;
        case (operation)
            tsync_pkg::OP_START:
            begin
                send       = 1'b1;
                send_phase = tsync_pkg::PH_SYNC;
                state_next = tsync_pkg::ST_WAIT_ACK;
            end
            tsync_pkg::OP_RECV:
            begin
                if (msg_is_timesync)
                begin
                    case (state_reg)
                        tsync_pkg::ST_IDLE, tsync_pkg::ST_SYNCED:
                        begin
                            if (msg_phase == tsync_pkg::PH_SYNC)
                            begin
                                latency_next = local_time;
                                send         = 1'b1;
                                send_phase   = tsync_pkg::PH_ACK;
                                state_next   = tsync_pkg::ST_WAIT_SET;
                            end
                            else if (msg_phase == tsync_pkg::PH_RESYNC &&
                                     state_reg == tsync_pkg::ST_SYNCED)
                            begin
                                offset_next = msg_timestamp + latency_reg - local_time;
                            end
                        end
                        tsync_pkg::ST_WAIT_ACK:
                        begin
                            if (msg_phase == tsync_pkg::PH_ACK)
                            begin
                                send       = 1'b1;
                                send_phase = tsync_pkg::PH_SET;
                                state_next = tsync_pkg::ST_IDLE;
                            end
                        end
                        tsync_pkg::ST_WAIT_SET:
                        begin
                            if (msg_phase == tsync_pkg::PH_SET)
                            begin
                                latency_next = half_trip;
                                offset_next  = msg_timestamp + half_trip - local_time;
                                state_next   = tsync_pkg::ST_SYNCED;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tsync_pkg::OP_RESYNC:
            begin
                send       = 1'b1;
                send_phase = tsync_pkg::PH_RESYNC;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_ctrl.send_valid = send;
        res_ctrl.send_phase = send ? send_phase : tsync_pkg::PH_SYNC;
        res_ctrl.busy       = state_next inside {tsync_pkg::ST_WAIT_ACK,
                                                 tsync_pkg::ST_WAIT_SET};
        res_addr            = send ? peer_addr : '0;
        res_timestamp       = send ? (local_time + offset_reg) : '0;
        res_synced_time     = local_time + offset_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tsync_pkg::ST_IDLE;
            latency_reg <= '0;
            offset_reg  <= '0;
        end
        else if (take)
        begin
            state_reg   <= state_next;
            latency_reg <= latency_next;
            offset_reg  <= offset_next;
        end
    end

endmodule

### rtl/tsync_out_reg.sv
// ----------------------------------------------------------------------------
// Time sync result register
// Holds one result until the consumer completes its transfer.
// ----------------------------------------------------------------------------
module tsync_out_reg #(
    parameter int TIME_WIDTH = tsync_pkg::TIME_WIDTH_DEF,
    parameter int ADDR_WIDTH = tsync_pkg::ADDR_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  hold_valid,
    output logic                  take,
    input  tsync_pkg::res_ctrl_t  res_ctrl,
    input  logic [ADDR_WIDTH-1:0] res_addr,
    input  logic [TIME_WIDTH-1:0] res_timestamp,
    input  logic [TIME_WIDTH-1:0] res_synced_time,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  send_valid,
    output logic [1:0]            send_phase,
    output logic [ADDR_WIDTH-1:0] send_addr,
    output logic [TIME_WIDTH-1:0] send_timestamp,
    output logic                  busy_res,
    output logic [TIME_WIDTH-1:0] synced_time
);

    logic                  valid_reg;
    logic                  valid_next;
    tsync_pkg::res_ctrl_t  ctrl_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic [TIME_WIDTH-1:0] timestamp_reg;
    logic [TIME_WIDTH-1:0] synced_time_reg;

    assign take = hold_valid && (!valid_reg || !result_stall);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctrl_reg        <= res_ctrl;
            addr_reg        <= res_addr;
            timestamp_reg   <= res_timestamp;
            synced_time_reg <= res_synced_time;
        end
    end

    assign result_valid   = valid_reg;
    assign send_valid     = ctrl_reg.send_valid;
    assign send_phase     = ctrl_reg.send_phase;
    assign send_addr      = addr_reg;
    assign send_timestamp = timestamp_reg;
    assign busy_res       = ctrl_reg.busy;
    assign synced_time    = synced_time_reg;

endmodule

### rtl/two_way_time_sync_fsm.sv
// ----------------------------------------------------------------------------
// Two-way time synchronization engine
// One node's side of a two-way time sync exchange: start, reply, latency
// and offset tracking, with every outgoing message stamped in synced time.
//
//   Channel   Handshake                    Payload
//   item      item_valid / item_stall      operation, local_time, peer_addr,
//                                          msg_is_timesync, msg_phase,
//                                          msg_timestamp
//   result    result_valid / result_stall  send_valid, send_phase, send_addr,
//                                          send_timestamp, busy_res, synced_time
//
// One item is taken per cycle while the result side does not stall; each
// result passes from the input register through the protocol core into the
// result register and transfers when the result side does not stall.
// The rate is set by the single pass from the input register through the
// protocol core to the result register.
// Reset clears the protocol state, latency, offset and both valid flags.
// A stall on the result side holds the result and backs up into item_stall.
// ----------------------------------------------------------------------------
module two_way_time_sync_fsm #(
    parameter int TIME_WIDTH = tsync_pkg::TIME_WIDTH_DEF,
    parameter int ADDR_WIDTH = tsync_pkg::ADDR_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            operation,
    input  logic [TIME_WIDTH-1:0] local_time,
    input  logic [ADDR_WIDTH-1:0] peer_addr,
    input  logic                  msg_is_timesync,
    input  logic [1:0]            msg_phase,
    input  logic [TIME_WIDTH-1:0] msg_timestamp,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  send_valid,
    output logic [1:0]            send_phase,
    output logic [ADDR_WIDTH-1:0] send_addr,
    output logic [TIME_WIDTH-1:0] send_timestamp,
    output logic                  busy_res,
    output logic [TIME_WIDTH-1:0] synced_time
);

    logic                  take;
    logic                  hold_valid;
    logic [1:0]            hold_operation;
    logic [TIME_WIDTH-1:0] hold_local_time;
    logic [ADDR_WIDTH-1:0] hold_peer_addr;
    logic                  hold_msg_is_timesync;
    logic [1:0]            hold_msg_phase;
    logic [TIME_WIDTH-1:0] hold_msg_timestamp;
    tsync_pkg::res_ctrl_t  res_ctrl;
    logic [ADDR_WIDTH-1:0] res_addr;
    logic [TIME_WIDTH-1:0] res_timestamp;
    logic [TIME_WIDTH-1:0] res_synced_time;

    tsync_in_reg #(
        .TIME_WIDTH (TIME_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_in_reg (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item_valid           (item_valid),
        .item_stall           (item_stall),
        .operation            (operation),
        .local_time           (local_time),
        .peer_addr            (peer_addr),
        .msg_is_timesync      (msg_is_timesync),
        .msg_phase            (msg_phase),
        .msg_timestamp        (msg_timestamp),
        .take                 (take),
        .hold_valid           (hold_valid),
        .hold_operation       (hold_operation),
        .hold_local_time      (hold_local_time),
        .hold_peer_addr       (hold_peer_addr),
        .hold_msg_is_timesync (hold_msg_is_timesync),
        .hold_msg_phase       (hold_msg_phase),
        .hold_msg_timestamp   (hold_msg_timestamp)
    );

    tsync_core #(
        .TIME_WIDTH (TIME_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .operation       (hold_operation),
        .local_time      (hold_local_time),
        .peer_addr       (hold_peer_addr),
        .msg_is_timesync (hold_msg_is_timesync),
        .msg_phase       (hold_msg_phase),
        .msg_timestamp   (hold_msg_timestamp),
        .res_ctrl        (res_ctrl),
        .res_addr        (res_addr),
        .res_timestamp   (res_timestamp),
        .res_synced_time (res_synced_time)
    );

    tsync_out_reg #(
        .TIME_WIDTH (TIME_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_out_reg (
        .clk             (clk),
        .rst_n           (rst_n),
        .hold_valid      (hold_valid),
        .take            (take),
        .res_ctrl        (res_ctrl),
        .res_addr        (res_addr),
        .res_timestamp   (res_timestamp),
        .res_synced_time (res_synced_time),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .send_valid      (send_valid),
        .send_phase      (send_phase),
        .send_addr       (send_addr),
        .send_timestamp  (send_timestamp),
        .busy_res        (busy_res),
        .synced_time     (synced_time)
    );

endmodule

### rtl/tsync_checker.sv
// ----------------------------------------------------------------------------
// Time sync port checker
// Watches the ports of the time synchronization engine over time.
// ----------------------------------------------------------------------------
`include "two_way_time_sync_fsm_defines.svh"

module tsync_checker #(
    parameter int TIME_WIDTH = tsync_pkg::TIME_WIDTH_DEF,
    parameter int ADDR_WIDTH = tsync_pkg::ADDR_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input logic                  send_valid,
    input logic [1:0]            send_phase,
    input logic [ADDR_WIDTH-1:0] send_addr,
    input logic [TIME_WIDTH-1:0] send_timestamp,
    input logic                  busy_res,
    input logic [TIME_WIDTH-1:0] synced_time
);

    // No result is offered while reset is applied.
    `TSYNC_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !result_valid, "result valid in reset")

    // A stalled result stays offered with the same contents.
    `TSYNC_ASSERT(a_result_holds, result_valid && result_stall |=> result_valid && $stable(send_addr) && $stable(synced_time), "stalled result changed")

    // The item side only stalls when a full result register is stalled.
    `TSYNC_ASSERT(a_stall_cause, item_stall |-> result_valid && result_stall, "item stall without result stall")

    // No item that sends a message changes the offset, so the stamp equals the synced time.
    `TSYNC_ASSERT(a_stamp_matches, result_valid && send_valid |-> send_timestamp == synced_time, "send stamp differs from synced time")

    // Sending SYNC or ACK always leaves the node waiting for the peer.
    `TSYNC_ASSERT(a_wait_after_send, result_valid && send_valid && (send_phase == tsync_pkg::PH_SYNC || send_phase == tsync_pkg::PH_ACK) |-> busy_res, "not busy after SYNC or ACK")

endmodule

bind two_way_time_sync_fsm tsync_checker #(
    .TIME_WIDTH (TIME_WIDTH),
    .ADDR_WIDTH (ADDR_WIDTH)
) u_tsync_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_stall     (item_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .send_valid     (send_valid),
    .send_phase     (send_phase),
    .send_addr      (send_addr),
    .send_timestamp (send_timestamp),
    .busy_res       (busy_res),
    .synced_time    (synced_time)
);
